>>> hw/rtl/ssn_pkg.sv
// Package with the element types and compare-exchange tables of the sorting network.
`default_nettype none

package ssn_pkg;

  // Element and vector sizes.
  localparam int ElemWidth     = 8;
  localparam int NumElems      = 6;
  localparam int MaxPairs      = 12;
  localparam int NumCounts     = 8;
  localparam int StepsPerStage = 3;
  localparam int NumStages     = MaxPairs / StepsPerStage;

  typedef logic [ElemWidth-1:0]                elem_t;
  typedef logic [NumElems-1:0][ElemWidth-1:0]  elems_t;
  typedef logic [2:0]                          count_t;
  typedef logic [2:0]                          pos_t;
  typedef logic [3:0]                          step_t;

  // Number of compare-exchanges in the network for each count.
  localparam step_t NetLen [NumCounts] = '{
    4'd0, 4'd0, 4'd1, 4'd3, 4'd5, 4'd9, 4'd12, 4'd0
  };

  // Lower position of each compare-exchange, per count.
  localparam pos_t NetLo [NumCounts][MaxPairs] = '{
    '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
    '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
    '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
    '{3'd0, 3'd0, 3'd1, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
    '{3'd0, 3'd1, 3'd0, 3'd2, 3'd1, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
    '{3'd0, 3'd0, 3'd1, 3'd2, 3'd0, 3'd2, 3'd1, 3'd1, 3'd3, 3'd0, 3'd0, 3'd0},
    '{3'd0, 3'd1, 3'd0, 3'd1, 3'd2, 3'd3, 3'd0, 3'd2, 3'd4, 3'd1, 3'd1, 3'd3},
    '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0}
  };

  // Upper position of each compare-exchange, per count.
  localparam pos_t NetHi [NumCounts][MaxPairs] = '{
    '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
    '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
    '{3'd1, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
    '{3'd2, 3'd1, 3'd2, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
    '{3'd2, 3'd3, 3'd1, 3'd3, 3'd2, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
    '{3'd4, 3'd2, 3'd3, 3'd4, 3'd1, 3'd3, 3'd4, 3'd2, 3'd4, 3'd0, 3'd0, 3'd0},
    '{3'd4, 3'd5, 3'd2, 3'd3, 3'd4, 3'd5, 3'd1, 3'd3, 3'd5, 3'd4, 3'd2, 3'd4},
    '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0}
  };

  // One compare-exchange of the network for this count; steps past the end do nothing.
  function automatic elems_t apply_step(elems_t v, count_t cnt, step_t step);
    elems_t r;
    pos_t   a;
    pos_t   b;
    elem_t  ea;
    elem_t  eb;
    r  = v;
    a  = NetLo[cnt][step];
    b  = NetHi[cnt][step];
    ea = v[a];
    eb = v[b];
    if (step < NetLen[cnt] && ea > eb) begin
      r[a] = eb;
      r[b] = ea;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/small_sorting_network.sv
// Top level of the six-element sorting network, a four-stage pipeline.
//
//   channel   handshake              payload
//   --------  ---------------------  -------------------------------
//   input     start_i, busy_o        count_i, value0_i .. value5_i
//   result    strobe_o               sorted0_o .. sorted5_o
//
// Each stage applies three compare-exchanges of the selected network, so the
// twelve-step worst case takes four register stages. A beat can enter every
// cycle. Its result appears on strobe_o as it leaves the last stage register.
// busy_o stays low: the receiver cannot stall, so the pipeline always moves.
// Reset clears the stage valid bits; the data registers are not reset.
`default_nettype none

module small_sorting_network
  import ssn_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  output logic                      busy_o,
  input  wire logic [2:0]           count_i,
  input  wire logic [ElemWidth-1:0] value0_i,
  input  wire logic [ElemWidth-1:0] value1_i,
  input  wire logic [ElemWidth-1:0] value2_i,
  input  wire logic [ElemWidth-1:0] value3_i,
  input  wire logic [ElemWidth-1:0] value4_i,
  input  wire logic [ElemWidth-1:0] value5_i,
  output logic                      strobe_o,
  output logic [ElemWidth-1:0]      sorted0_o,
  output logic [ElemWidth-1:0]      sorted1_o,
  output logic [ElemWidth-1:0]      sorted2_o,
  output logic [ElemWidth-1:0]      sorted3_o,
  output logic [ElemWidth-1:0]      sorted4_o,
  output logic [ElemWidth-1:0]      sorted5_o
);

  // Stage registers: valid bit, count and element vector travel together.
  logic   [NumStages-1:0] vld_q, vld_d;
  count_t                 cnt_q  [NumStages];
  count_t                 cnt_d  [NumStages];
  elems_t                 data_q [NumStages];
  elems_t                 data_d [NumStages];

  // Input beat as a vector.
  elems_t in_vec;
  assign in_vec = {value5_i, value4_i, value3_i, value2_i, value1_i, value0_i};

  // The pipeline never stalls.
  assign busy_o = 1'b0;

  // Each stage takes its predecessor and applies its three compare-exchanges.
  always_comb begin
    elems_t v;
    count_t c;
    logic   vl;
    for (int s = 0; s < NumStages; s++) begin
      if (s == 0) begin
        v  = in_vec;
        c  = count_i;
        vl = start_i & ~busy_o;
      end else begin
        v  = data_q[s-1];
        c  = cnt_q[s-1];
        vl = vld_q[s-1];
      end
      for (int k = 0; k < StepsPerStage; k++) begin
        v = apply_step(v, c, step_t'(s * StepsPerStage + k));
      end
      vld_d[s]  = vl;
      cnt_d[s]  = c;
      data_d[s] = v;
    end
  end

  // Valid bits are control state and are reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Payload registers load every cycle.
  always_ff @(posedge clk_i) begin
    for (int s = 0; s < NumStages; s++) begin
      cnt_q[s]  <= cnt_d[s];
      data_q[s] <= data_d[s];
    end
  end

  // Result beat from the last stage.
  assign strobe_o  = vld_q[NumStages-1];
  assign sorted0_o = data_q[NumStages-1][0];
  assign sorted1_o = data_q[NumStages-1][1];
  assign sorted2_o = data_q[NumStages-1][2];
  assign sorted3_o = data_q[NumStages-1][3];
  assign sorted4_o = data_q[NumStages-1][4];
  assign sorted5_o = data_q[NumStages-1][5];

endmodule

`default_nettype wire

>>> hw/rtl/ssn_checker.sv
// Port-level checker for the sorting network, bound to the top level.
`default_nettype none

module ssn_checker
  import ssn_pkg::*;
(
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 start_i,
  input wire logic                 busy_o,
  input wire logic [2:0]           count_i,
  input wire logic [ElemWidth-1:0] value0_i,
  input wire logic [ElemWidth-1:0] value1_i,
  input wire logic [ElemWidth-1:0] value2_i,
  input wire logic [ElemWidth-1:0] value3_i,
  input wire logic [ElemWidth-1:0] value4_i,
  input wire logic [ElemWidth-1:0] value5_i,
  input wire logic                 strobe_o,
  input wire logic [ElemWidth-1:0] sorted0_o,
  input wire logic [ElemWidth-1:0] sorted1_o,
  input wire logic [ElemWidth-1:0] sorted2_o,
  input wire logic [ElemWidth-1:0] sorted3_o,
  input wire logic [ElemWidth-1:0] sorted4_o,
  input wire logic [ElemWidth-1:0] sorted5_o
);

  // An accepted beat always produces a result after the pipeline latency.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##NumStages strobe_o)
    else $error("accepted beat produced no result");

  // No result appears without a matching accepted beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> $past(start_i && !busy_o, NumStages))
    else $error("result without an accepted beat");

  // A full six-element sort comes out in ascending order.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && $past(count_i, NumStages) == 3'd6) |->
      (sorted0_o <= sorted1_o && sorted1_o <= sorted2_o && sorted2_o <= sorted3_o &&
       sorted3_o <= sorted4_o && sorted4_o <= sorted5_o))
    else $error("six-element result not ascending");

  // Counts of zero or one leave every element where it was.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && ($past(count_i, NumStages) == 3'd0 ||
                  $past(count_i, NumStages) == 3'd1)) |->
      (sorted0_o == $past(value0_i, NumStages) && sorted1_o == $past(value1_i, NumStages) &&
       sorted2_o == $past(value2_i, NumStages) && sorted3_o == $past(value3_i, NumStages) &&
       sorted4_o == $past(value4_i, NumStages) && sorted5_o == $past(value5_i, NumStages)))
    else $error("pass-through count changed the elements");

endmodule

bind small_sorting_network ssn_checker u_ssn_checker (.*);

`default_nettype wire
